/* src/dip_set_dueling_replacement_macros.svh */
// Assertion macros for the set-dueling replacement block.
// Each macro takes a label, the clock, the reset, two expressions and a message.
`ifndef DIP_SET_DUELING_REPLACEMENT_MACROS_SVH
`define DIP_SET_DUELING_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSDR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DSDR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DSDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* src/dsdr_pkg.sv */
`timescale 1ns / 1ps

package dsdr_pkg;

  // Default geometry of the cache that the block serves.
  localparam int DEF_WAYS = 8;
  localparam int DEF_SETS = 64;

  // Field widths of the item ports.
  localparam int OP_W   = 1;
  localparam int SET_W  = 6;
  localparam int WAY_W  = 3;
  localparam int CNT_W  = 20;

  // Epoch and leader counters saturate at this value.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Epoch length after reset.
  localparam logic [CNT_W-1:0] EPOCH_RESET = CNT_W'(100000);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_QUERY  = 1'b0;
  localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

  // Leader sets.
  localparam logic [SET_W-1:0] LRU_LEADER = 6'd0;
  localparam logic [SET_W-1:0] LIP_LEADER = 6'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take the item and read its set
    logic clr;      // write one cleared valid row
    logic mul_lru;  // form the LRU side of the duel
    logic mul_lip;  // form the LIP side of the duel
    logic decide;   // settle the duel and clear the counters
    logic finish;   // write the set back and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at the last row
    logic dec_now;   // the offered item ends the epoch
    logic out_free;  // the result register can take a result
  } sts_t;

endpackage

/* src/dsdr_dp.sv */
`timescale 1ns / 1ps

module dsdr_dp #(
  parameter int WAYS = dsdr_pkg::DEF_WAYS,
  parameter int SETS = dsdr_pkg::DEF_SETS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dsdr_pkg::cmd_t               cmd,
  output dsdr_pkg::sts_t               sts,
  input  logic                         cfg_valid,
  input  logic [dsdr_pkg::CNT_W-1:0]   cfg_data,
  input  logic [dsdr_pkg::OP_W-1:0]    opcode,
  input  logic [dsdr_pkg::SET_W-1:0]   set_index,
  input  logic [dsdr_pkg::WAY_W-1:0]   way_index,
  input  logic                         hit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dsdr_pkg::WAY_W-1:0]   victim_way,
  output logic                         lru_mode
);

  localparam int AW = $clog2(SETS);
  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = dsdr_pkg::CNT_W;

  // Configuration and duel state.
  logic [CW-1:0]   epoch_length;
  logic [CW-1:0]   epoch_count;
  logic [CW-1:0]   lru_acc;
  logic [CW-1:0]   lru_hits;
  logic [CW-1:0]   lip_acc;
  logic [CW-1:0]   lip_hits;
  logic            use_lru;
  logic [2*CW-1:0] prod_lru;
  logic [2*CW-1:0] prod_lip;
  logic [2*CW-1:0] mul_out;
  logic [CW-1:0]   epoch_inc;
  logic            duel_win;

  // Item held during its operation.
  logic [dsdr_pkg::OP_W-1:0]  op_q;
  logic [dsdr_pkg::SET_W-1:0] set_q;
  logic [dsdr_pkg::WAY_W-1:0] way_q;
  logic                       hit_q;

  // Set state memories and the clearing pass.
  logic [WAYS-1:0]    valid_mem [SETS];
  logic [WAYS*RW-1:0] rank_mem  [SETS];
  logic [WAYS-1:0]    vrow;
  logic [WAYS*RW-1:0] rrow;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      wr_addr;
  logic               valid_we;
  logic [WAYS-1:0]    valid_wd;
  logic               rank_we;

  // Row logic.
  logic               set_ok;
  logic               way_ok;
  logic [RW-1:0]      way_w;
  logic               was_valid;
  logic [RW-1:0]      old_rank;
  logic [RW:0]        pre_rank;
  logic               lru_ins;
  logic [WAYS-1:0]    new_v;
  logic [WAYS*RW-1:0] new_r;
  logic [RW-1:0]      vic;
  logic               found;
  logic [RW-1:0]      best_rank;

  // Configuration register, written whenever the port offers data.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_length <= dsdr_pkg::EPOCH_RESET;
    end else if (cfg_valid) begin
      epoch_length <= cfg_data;
    end
  end

  // The epoch ends when the incremented count reaches the length.
  assign epoch_inc   = (epoch_count == dsdr_pkg::CNT_MAX) ? epoch_count : epoch_count + 1'b1;
  assign sts.dec_now = (opcode == dsdr_pkg::OP_UPDATE) && (epoch_inc >= epoch_length);

  // One shared multiplier forms both sides of the cross-multiplication.
  assign mul_out = cmd.mul_lip ? (2*CW)'(lip_hits) * (2*CW)'(lru_acc)
                               : (2*CW)'(lru_hits) * (2*CW)'(lip_acc);

  always_ff @(posedge clk) begin
    if (cmd.mul_lru) begin
      prod_lru <= mul_out;
    end
    if (cmd.mul_lip) begin
      prod_lip <= mul_out;
    end
  end

  // A leader without accesses counts as rate zero.
  always_comb begin
    if (lru_acc == '0) begin
      duel_win = 1'b0;
    end else if (lip_acc == '0) begin
      duel_win = (lru_hits != '0);
    end else begin
      duel_win = (prod_lru > prod_lip);
    end
  end

  // Epoch and leader counters, counted when an update item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_count <= '0;
      lru_acc     <= '0;
      lru_hits    <= '0;
      lip_acc     <= '0;
      lip_hits    <= '0;
      use_lru     <= 1'b1;
    end else if (cmd.decide) begin
      use_lru     <= duel_win;
      epoch_count <= '0;
      lru_acc     <= '0;
      lru_hits    <= '0;
      lip_acc     <= '0;
      lip_hits    <= '0;
    end else if (cmd.accept && opcode == dsdr_pkg::OP_UPDATE) begin
      epoch_count <= epoch_inc;
      if (set_index == dsdr_pkg::LRU_LEADER) begin
        if (lru_acc != dsdr_pkg::CNT_MAX) begin
          lru_acc <= lru_acc + 1'b1;
        end
        if (hit && lru_hits != dsdr_pkg::CNT_MAX) begin
          lru_hits <= lru_hits + 1'b1;
        end
      end
      if (set_index == dsdr_pkg::LIP_LEADER) begin
        if (lip_acc != dsdr_pkg::CNT_MAX) begin
          lip_acc <= lip_acc + 1'b1;
        end
        if (hit && lip_hits != dsdr_pkg::CNT_MAX) begin
          lip_hits <= lip_hits + 1'b1;
        end
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= opcode;
      set_q <= set_index;
      way_q <= way_index;
      hit_q <= hit;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == AW'(SETS - 1));

  // Memory write port controls.
  assign set_ok   = (32'(set_q) < SETS);
  assign way_ok   = (32'(way_q) < WAYS);
  assign wr_addr  = cmd.clr ? clr_addr : AW'(set_q);
  assign rank_we  = cmd.finish && (op_q == dsdr_pkg::OP_UPDATE) && set_ok && way_ok;
  assign valid_we = cmd.clr || rank_we;
  assign valid_wd = cmd.clr ? '0 : new_v;

  // Valid bits of each set, read when an item is taken.
  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[wr_addr] <= valid_wd;
    end
    if (cmd.accept) begin
      vrow <= valid_mem[AW'(set_index)];
    end
  end

  // Recency ranks of each set.
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[wr_addr] <= new_r;
    end
    if (cmd.accept) begin
      rrow <= rank_mem[AW'(set_index)];
    end
  end

  // Victim: the first invalid way, else the lowest way with the oldest rank.
  always_comb begin
    vic       = '0;
    found     = 1'b0;
    best_rank = rrow[RW-1:0];
    for (int i = 0; i < WAYS; i++) begin
      if (!found && !vrow[i]) begin
        vic   = RW'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 1; i < WAYS; i++) begin
        if (rrow[i*RW +: RW] > best_rank) begin
          vic       = RW'(i);
          best_rank = rrow[i*RW +: RW];
        end
      end
    end
    if (WAYS == 1 || !set_ok) begin
      vic = '0;
    end
  end

  // New row for an update: promotion to the front, a fill at the back, or no change.
  assign way_w     = RW'(way_q);
  assign was_valid = vrow[way_w];
  assign old_rank  = rrow[way_w*RW +: RW];
  assign pre_rank  = was_valid ? {1'b0, old_rank} : (RW+1)'(WAYS);
  assign lru_ins   = (use_lru && set_q != dsdr_pkg::LIP_LEADER) ||
                     (set_q == dsdr_pkg::LRU_LEADER);

  always_comb begin
    new_v = vrow;
    new_r = rrow;
    if (lru_ins || hit_q) begin
      for (int i = 0; i < WAYS; i++) begin
        if (int'(way_w) != i && vrow[i] && {1'b0, rrow[i*RW +: RW]} < pre_rank &&
            int'(rrow[i*RW +: RW]) + 1 < WAYS) begin
          new_r[i*RW +: RW] = rrow[i*RW +: RW] + 1'b1;
        end
      end
      new_r[way_w*RW +: RW] = '0;
      new_v[way_w]          = 1'b1;
    end else if (!was_valid) begin
      new_v[way_w]          = 1'b1;
      new_r[way_w*RW +: RW] = RW'($countones(new_v) - 1);
    end
  end

  // Result register; it takes a new result once the old one has left.
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      victim_way <= (op_q == dsdr_pkg::OP_QUERY) ? dsdr_pkg::WAY_W'(vic) : '0;
      lru_mode   <= use_lru;
    end
  end

endmodule

/* src/dsdr_ctrl.sv */
`timescale 1ns / 1ps

module dsdr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsdr_pkg::sts_t sts,
  output dsdr_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MULA  = 3'd2;
  localparam logic [2:0] S_MULB  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencing: clear after reset, then take an item, settle the duel when the epoch ends, then do the row.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.dec_now ? S_MULA : S_ROW;
        end
      end
      S_MULA: begin
        cmd.mul_lru = 1'b1;
        state_next  = S_MULB;
      end
      S_MULB: begin
        cmd.mul_lip = 1'b1;
        state_next  = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/dip_set_dueling_replacement.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    opcode, set_index, way_index, hit
// out       out_valid / out_ready  victim_way, lru_mode
// cfg       cfg_valid / cfg_ready  cfg_data (epoch_length)
//
// An item first reads its set row, then in the row state writes it back and
// loads the result. An update that ends an epoch first passes through S_MULA,
// S_MULB and S_DEC, as one multiplier forms the two products of the duel in
// turn before the comparison. After reset a clearing pass zeroes the valid
// bits, one set per cycle; items wait, configuration writes are taken.
// A result waiting in the output register holds the next item in its row cycle.
`timescale 1ns / 1ps
`include "dip_set_dueling_replacement_macros.svh"

module dip_set_dueling_replacement #(
  parameter int WAYS = dsdr_pkg::DEF_WAYS,
  parameter int SETS = dsdr_pkg::DEF_SETS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dsdr_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dsdr_pkg::OP_W-1:0]    opcode,
  input  logic [dsdr_pkg::SET_W-1:0]   set_index,
  input  logic [dsdr_pkg::WAY_W-1:0]   way_index,
  input  logic                         hit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dsdr_pkg::WAY_W-1:0]   victim_way,
  output logic                         lru_mode
);

  dsdr_pkg::cmd_t cmd;
  dsdr_pkg::sts_t sts;

  // The register is always writable.
  assign cfg_ready = 1'b1;

  dsdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsdr_dp #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .set_index  (set_index),
    .way_index  (way_index),
    .hit        (hit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .victim_way (victim_way),
    .lru_mode   (lru_mode)
  );

  // One item at a time: after an item is taken the input closes.
  `DSDR_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input open while busy")

  // A result is never loaded over one that has not been taken.
  `DSDR_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.finish, !out_valid || out_ready, "result overwritten")

  // The controller issues at most one command per cycle.
  `DSDR_ASSERT_SAME(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "several commands at once")

  // The duel is settled only after both products are formed.
  `DSDR_ASSERT_NEXT(a_dec_order, clk, rst, cmd.mul_lip, cmd.decide, "duel not settled")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int WAYS = dsdr_pkg::DEF_WAYS;
  localparam int SETS = dsdr_pkg::DEF_SETS;
  localparam int OP_W = dsdr_pkg::OP_W;
  localparam int SET_W = dsdr_pkg::SET_W;
  localparam int WAY_W = dsdr_pkg::WAY_W;
  localparam int CNT_W = dsdr_pkg::CNT_W;
  localparam int PROD_W = 2 * CNT_W;
  localparam int PHASE_ITEMS = 88;
  localparam int SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One item on the input channel.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SET_W-1:0] sel_set;
    logic [WAY_W-1:0] sel_way;
    logic             was_hit;
  } access_t;

  // One item on the output channel.
  typedef struct packed {
    logic [WAY_W-1:0] victim;
    logic             mode;
  } pick_t;

  typedef enum bit {ROW_ACCESS, ROW_EPOCH} row_kind_t;

  // A directed row either writes the epoch length or sends one access.
  typedef struct packed {
    row_kind_t        kind;
    logic [CNT_W-1:0] epoch;
    access_t          acc;
    bit               typed;
    pick_t            want;
  } step_t;

  // Settings of one random phase, in percent where not a length.
  typedef struct packed {
    logic [CNT_W-1:0] epoch;
    logic [6:0]       snd_idle;
    logic [6:0]       rcv_stall;
    logic [6:0]       lru_hit;
    logic [6:0]       lip_hit;
  } phase_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      opcode;
  logic [SET_W-1:0]     set_index;
  logic [WAY_W-1:0]     way_index;
  logic                 hit;
  logic                 out_valid;
  logic                 out_ready;
  logic [WAY_W-1:0]     victim_way;
  logic                 lru_mode;

  // Our own copy of the replacement state.
  logic [WAY_W-1:0]     way_age [SETS][WAYS];
  bit                   way_ok [SETS][WAYS];
  logic [CNT_W-1:0]     epoch_len = dsdr_pkg::EPOCH_RESET;
  logic [CNT_W-1:0]     epoch_seen = '0;
  logic [CNT_W-1:0]     lru_accesses = '0;
  logic [CNT_W-1:0]     lru_hits = '0;
  logic [CNT_W-1:0]     lip_accesses = '0;
  logic [CNT_W-1:0]     lip_hits = '0;
  logic                 lru_follow = 1'b1;

  pick_t                due_results [$];
  int                   fail_n = 0;
  int                   snd_idle_pct = 0;
  int                   rcv_stall_pct = 0;

  step_t script [26] = '{
    // Straight after reset every set is empty and LRU mode is on.
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd0,  3'd0, 1'b0}, 1'b1, '{3'd0, 1'b1}},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd63, 3'd0, 1'b0}, 1'b1, '{3'd0, 1'b1}},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd0,  3'd0, 1'b0}, 1'b1, '{3'd0, 1'b1}},
    // Way 0 is now valid, so the first invalid way is 1; way and hit are ignored.
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd0,  3'd7, 1'b1}, 1'b1, '{3'd1, 1'b1}},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd63, 3'd7, 1'b1}, 1'b1, '{3'd0, 1'b1}},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd63, 3'd0, 1'b0}, 1'b1, '{3'd0, 1'b1}},
    // Fill a whole set, then pick by age, refresh the oldest and pick again.
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd0, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd1, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd2, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd3, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd4, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd5, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd6, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd7, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd2,  3'd0, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd2,  3'd0, 1'b1}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd2,  3'd0, 1'b0}, 1'b0, '0},
    // Zero epoch length: the duel is settled on every update.
    '{ROW_EPOCH,  '0, '0, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd5,  3'd3, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd1,  3'd0, 1'b1}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd9,  3'd4, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd9,  3'd5, 1'b0}, 1'b0, '0},
    // Longest epoch length.
    '{ROW_EPOCH,  dsdr_pkg::CNT_MAX, '0, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd0,  3'd1, 1'b1}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_UPDATE, 6'd1,  3'd1, 1'b0}, 1'b0, '0},
    '{ROW_ACCESS, '0, '{dsdr_pkg::OP_QUERY,  6'd9,  3'd0, 1'b0}, 1'b0, '0}
  };

  // The third phase shortens the epoch below the count left by the second.
  phase_t phases [8] = '{
    '{20'd5,             7'd0,  7'd0,  7'd80, 7'd30},
    '{dsdr_pkg::CNT_MAX, 7'd61, 7'd0,  7'd40, 7'd70},
    '{20'd3,             7'd0,  7'd61, 7'd20, 7'd90},
    '{20'd12,            7'd36, 7'd36, 7'd70, 7'd50},
    '{20'd1,             7'd0,  7'd0,  7'd60, 7'd60},
    '{20'd0,             7'd61, 7'd0,  7'd50, 7'd50},
    '{20'd20,            7'd0,  7'd61, 7'd90, 7'd10},
    '{20'd9,             7'd36, 7'd36, 7'd30, 7'd80}
  };

  dip_set_dueling_replacement dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .set_index  (set_index),
    .way_index  (way_index),
    .hit        (hit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .victim_way (victim_way),
    .lru_mode   (lru_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (v < dsdr_pkg::CNT_MAX) ? v + 1'b1 : v;
  endfunction

  // First invalid way, else the lowest-numbered way among the oldest.
  function automatic logic [WAY_W-1:0] victim_of(logic [SET_W-1:0] s);
    int best = 0;
    if (WAYS == 1) return '0;
    for (int i = 0; i < WAYS; i++)
      if (!way_ok[s][i]) return WAY_W'(i);
    for (int i = 1; i < WAYS; i++)
      if (way_age[s][i] > way_age[s][best]) best = i;
    return WAY_W'(best);
  endfunction

  // LRU insertion: the way becomes the newest and younger ways age by one.
  function automatic void move_to_front(logic [SET_W-1:0] s, logic [WAY_W-1:0] w, bit was);
    int old_rank = was ? int'(way_age[s][w]) : WAYS;
    for (int i = 0; i < WAYS; i++)
      if (i != w && way_ok[s][i] && way_age[s][i] < old_rank && way_age[s][i] + 1 < WAYS)
        way_age[s][i] = way_age[s][i] + 1'b1;
    way_age[s][w] = '0;
    way_ok[s][w] = 1'b1;
  endfunction

  // Compare the leader hit rates by cross-multiplication and start a new epoch.
  function automatic void settle_duel();
    logic [PROD_W-1:0] lru_side;
    logic [PROD_W-1:0] lip_side;
    lru_side = PROD_W'(lru_hits) * PROD_W'(lip_accesses);
    lip_side = PROD_W'(lip_hits) * PROD_W'(lru_accesses);
    if (lru_accesses == 0) lru_follow = 1'b0;
    else if (lip_accesses == 0) lru_follow = (lru_hits != 0);
    else lru_follow = (lru_side > lip_side);
    epoch_seen = '0;
    lru_accesses = '0;
    lru_hits = '0;
    lip_accesses = '0;
    lip_hits = '0;
  endfunction

  // Apply one accepted item to our state and return the result it must give.
  function automatic pick_t dip_outcome(access_t a);
    pick_t r;
    bit was;
    int n;
    r.victim = '0;
    if (a.op == dsdr_pkg::OP_QUERY) begin
      r.victim = victim_of(a.sel_set);
    end else begin
      epoch_seen = sat_bump(epoch_seen);
      if (a.sel_set == dsdr_pkg::LRU_LEADER) begin
        lru_accesses = sat_bump(lru_accesses);
        if (a.was_hit) lru_hits = sat_bump(lru_hits);
      end
      if (a.sel_set == dsdr_pkg::LIP_LEADER) begin
        lip_accesses = sat_bump(lip_accesses);
        if (a.was_hit) lip_hits = sat_bump(lip_hits);
      end
      if (epoch_seen >= epoch_len) settle_duel();
      was = way_ok[a.sel_set][a.sel_way];
      if ((lru_follow && a.sel_set != dsdr_pkg::LIP_LEADER) ||
          a.sel_set == dsdr_pkg::LRU_LEADER || a.was_hit) begin
        move_to_front(a.sel_set, a.sel_way, was);
      end else if (!was) begin
        // LIP miss: the new way goes in at the back of the valid ways.
        way_ok[a.sel_set][a.sel_way] = 1'b1;
        n = 0;
        for (int i = 0; i < WAYS; i++)
          if (way_ok[a.sel_set][i]) n++;
        way_age[a.sel_set][a.sel_way] = WAY_W'(n - 1);
      end
    end
    r.mode = lru_follow;
    return r;
  endfunction

  // Send one item, with random idle cycles first, and record its result.
  task automatic issue(input access_t a, input bit typed, input pick_t want);
    pick_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= a.op;
    set_index <= a.sel_set;
    way_index <= a.sel_way;
    hit       <= a.was_hit;
    do @(posedge clk); while (!in_ready);
    r = dip_outcome(a);
    due_results.push_back(typed ? want : r);
  endtask

  // Write the epoch length once every result in flight has come back.
  task automatic set_epoch(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    epoch_len = v;
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin : result_side
    pick_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected item: victim_way %0d lru_mode %0d",
                 $time, victim_way, lru_mode);
        fail_n++;
      end else begin
        want = due_results.pop_front();
        if (victim_way !== want.victim) begin
          $display("%0t: victim_way expected %0d, got %0d", $time, want.victim, victim_way);
          fail_n++;
        end
        if (lru_mode !== want.mode) begin
          $display("%0t: lru_mode expected %0d, got %0d", $time, want.mode, lru_mode);
          fail_n++;
        end
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= rcv_stall_pct);
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cycle_n;
    cycle_n = 0;
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    access_t a;
    logic [SET_W-1:0] s;
    logic [WAY_W-1:0] w;
    int hit_pct;
    int sent;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    opcode    <= dsdr_pkg::OP_QUERY;
    set_index <= '0;
    way_index <= '0;
    hit       <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (script[i]) begin
      if (script[i].kind == ROW_EPOCH) set_epoch(script[i].epoch);
      else issue(script[i].acc, script[i].typed, script[i].want);
    end

    // Random phases: mostly queries followed by fills of the chosen way, and
    // hits on resident ways, on a few busy sets including both leaders.
    foreach (phases[p]) begin
      set_epoch(phases[p].epoch);
      snd_idle_pct  = phases[p].snd_idle;
      rcv_stall_pct = phases[p].rcv_stall;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        s = ($urandom_range(99) < 70) ? SET_W'($urandom_range(5))
                                      : SET_W'($urandom_range(63));
        if (s == dsdr_pkg::LRU_LEADER) hit_pct = phases[p].lru_hit;
        else if (s == dsdr_pkg::LIP_LEADER) hit_pct = phases[p].lip_hit;
        else hit_pct = 50;
        w = WAY_W'($urandom_range(WAYS - 1));
        if ($urandom_range(99) < 20) begin
          // Noise: any field value at all.
          a.op      = OP_W'($urandom_range(1));
          a.sel_set = SET_W'($urandom_range(63));
          a.sel_way = WAY_W'($urandom_range(7));
          a.was_hit = 1'($urandom_range(1));
          issue(a, 1'b0, '0);
          sent++;
        end else if ($urandom_range(99) < hit_pct && way_ok[s][w]) begin
          a = '{dsdr_pkg::OP_UPDATE, s, w, 1'b1};
          issue(a, 1'b0, '0);
          sent++;
        end else begin
          a = '{dsdr_pkg::OP_QUERY, s, WAY_W'($urandom_range(7)), 1'($urandom_range(1))};
          issue(a, 1'b0, '0);
          a = '{dsdr_pkg::OP_UPDATE, s, victim_of(s), 1'b0};
          issue(a, 1'b0, '0);
          sent += 2;
        end
      end
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_n == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* dip_set_dueling_replacement.f */
+incdir+src
src/dsdr_pkg.sv
src/dsdr_dp.sv
src/dsdr_ctrl.sv
src/dip_set_dueling_replacement.sv
tb/testbench.sv
